>>> sv/skm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package skm_pkg;

    localparam int MAX_STATES = 32;
    localparam int MAX_TERMS  = 8;
    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int TIDX_W     = $clog2(MAX_TERMS);
    localparam int TCNT_W     = $clog2(MAX_TERMS + 1);
    localparam int COV_AW     = 2 * IDX_W;
    localparam int ACT_W      = 3;
    localparam int STAT_W     = 3;
    localparam int CFG_W      = 6;
    localparam int W_W        = 63;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam int DIV_STEPS  = 128;
    localparam int DIV_CW     = $clog2(DIV_STEPS);

    typedef logic signed [63:0] q_t;

    localparam q_t Q_MAX = {1'b0, {63{1'b1}}};
    localparam q_t Q_MIN = {1'b1, {63{1'b0}}};

    localparam logic [ACT_W-1:0] ACT_LOAD_X = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_P = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_X = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ_P = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADIDX = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_REPEAT = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONPOS = 3'd4;

    function automatic logic [63:0] mag_of(input q_t v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic q_t from_mag(input logic [63:0] m, input logic neg);
        q_t r;
        if (neg)
        begin
            r = m[63] ? Q_MIN : q_t'(~m + 64'd1);
        end
        else
        begin
            r = m[63] ? Q_MAX : q_t'(m);
        end
        return r;
    endfunction

    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic q_t sat_sub(input q_t a, input q_t b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

endpackage
`default_nettype wire

>>> sv/skm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface skm_in_if;
    logic                             valid;
    logic                             ready;
    logic [skm_pkg::ACT_W-1:0]        action;
    logic [skm_pkg::IDX_W-1:0]        index_a;
    logic [skm_pkg::IDX_W-1:0]        index_b;
    logic signed [63:0]               value;
    logic [skm_pkg::W_W-1:0]          weight;

    modport source (output valid, action, index_a, index_b, value, weight, input ready);
    modport sink (input valid, action, index_a, index_b, value, weight, output ready);
endinterface
`default_nettype wire

>>> sv/skm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface skm_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [63:0]               result_value;
    logic [skm_pkg::STAT_W-1:0]       status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

>>> sv/skm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module skm_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire skm_pkg::q_t a,
    input  wire skm_pkg::q_t b,
    output logic             done,
    output skm_pkg::q_t      prod
);

    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [1:0]   step_reg;
    logic         busy_reg;
    logic         fin_reg;
    logic         done_reg;
    skm_pkg::q_t  prod_reg;

    logic [31:0]  ha;
    logic [31:0]  hb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] rnd;
    logic [63:0]  mag;

    always_comb
    begin
        ha = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        hb = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = ha * hb;
        case (step_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        rnd = acc_reg + (128'd1 << 31);
        mag = (|rnd[127:96]) ? {64{1'b1}} : rnd[95:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= skm_pkg::mag_of(a);
            mb_reg  <= skm_pkg::mag_of(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
        if (fin_reg)
        begin
            prod_reg <= skm_pkg::from_mag(mag, neg_reg);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> sv/skm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module skm_div (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] num,
    input  wire logic [63:0]  den,
    input  wire logic         neg,
    output logic              done,
    output skm_pkg::q_t       quo
);

    logic [127:0]               n_reg;
    logic [63:0]                r_reg;
    logic [127:0]               q_reg;
    logic [63:0]                d_reg;
    logic                       neg_reg;
    logic [skm_pkg::DIV_CW-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       fin_reg;
    logic                       done_reg;
    skm_pkg::q_t                quo_reg;

    logic [64:0] r2;
    logic        ge;
    logic [64:0] rs;

    always_comb
    begin
        r2 = {r_reg, n_reg[127]};
        ge = r2 >= {1'b0, d_reg};
        rs = r2 - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == skm_pkg::DIV_CW'(skm_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num;
            d_reg   <= den;
            neg_reg <= neg;
            r_reg   <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[126:0], 1'b0};
            r_reg <= ge ? rs[63:0] : r2[63:0];
            q_reg <= {q_reg[126:0], ge};
        end
        if (fin_reg)
        begin
            quo_reg <= (|q_reg[127:64]) ? skm_pkg::from_mag({64{1'b1}}, neg_reg)
                                        : skm_pkg::from_mag(q_reg[63:0], neg_reg);
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

>>> sv/sequential_kalman_measurement_update_top.sv
// Sequential scalar Kalman measurement update, signed Q31.32.
// in_ch (sink): one word per command: load/read state or covariance element,
//   add a coefficient term, or run the update with measured value and weight.
// out_ch (source): exactly one word per command: result_value and status.
// APB port: register 0 (byte address 0) is state_count; pready is always high.
// An update is paced by the single 32x32 multiply unit and the
//   bit-serial divider (one divide for 1/W, one per gain).
// One command is in flight at a time; in_ch.ready is high only when idle.
// A finished word sits in the output register; a new command is accepted
// while it waits, and the next result holds until out_ch.ready takes it.
// Reset clears the term buffer and the sequencer and sets state_count to 32;
// state, covariance and scratch memories are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module sequential_kalman_measurement_update_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    skm_in_if.sink                             in_ch,
    skm_out_if.source                          out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [skm_pkg::APB_AW-1:0]    paddr,
    input  wire logic [skm_pkg::APB_DW-1:0]    pwdata,
    output logic [skm_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int IW = skm_pkg::IDX_W;
    localparam int TW = skm_pkg::TIDX_W;
    localparam int CW = skm_pkg::TCNT_W;
    localparam int AW = skm_pkg::COV_AW;
    localparam int NS = skm_pkg::MAX_STATES;
    localparam int NT = skm_pkg::MAX_TERMS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EXEC  = 10'b0000000010,
        S_READ  = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_RD    = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_ACC   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_WR2   = 10'b0100000000,
        S_RESP  = 10'b1000000000
    } state_t;

    typedef enum logic [6:0] {
        PH_M    = 7'b0000001,
        PH_GM   = 7'b0000010,
        PH_BETA = 7'b0000100,
        PH_GAIN = 7'b0001000,
        PH_GX   = 7'b0010000,
        PH_X    = 7'b0100000,
        PH_P    = 7'b1000000
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [skm_pkg::ACT_W-1:0]  act_reg, act_next;
    logic [IW-1:0]              a_reg, a_next;
    logic [IW-1:0]              b_reg, b_next;
    skm_pkg::q_t                val_reg, val_next;
    logic [skm_pkg::W_W-1:0]    w_reg, w_next;
    logic [skm_pkg::CFG_W-1:0]  sc_reg;

    logic [IW-1:0]              tidx_reg [NT];
    logic [IW-1:0]              tidx_next [NT];
    skm_pkg::q_t                tcoef_reg [NT];
    skm_pkg::q_t                tcoef_next [NT];
    logic [CW-1:0]              tcnt_reg, tcnt_next;

    logic [IW-1:0]              i_reg, i_next;
    logic [IW-1:0]              j_reg, j_next;
    skm_pkg::q_t                acc_reg, acc_next;
    skm_pkg::q_t                beta_reg, beta_next;
    skm_pkg::q_t                innov_reg, innov_next;
    skm_pkg::q_t                pv_reg, pv_next;
    skm_pkg::q_t                res_val_reg, res_val_next;
    logic [skm_pkg::STAT_W-1:0] res_st_reg, res_st_next;

    logic                       out_valid_reg, out_valid_next;
    skm_pkg::q_t                out_val_reg, out_val_next;
    logic [skm_pkg::STAT_W-1:0] out_st_reg, out_st_next;

    skm_pkg::q_t cov_mem [NS*NS];
    skm_pkg::q_t sv_mem [NS];
    skm_pkg::q_t mv_mem [NS];
    skm_pkg::q_t gn_mem [NS];

    logic          cov_we, cov_re, sv_we, sv_re, mv_we, mv_re, gn_we, gn_re;
    logic [AW-1:0] cov_wa, cov_ra;
    logic [IW-1:0] sv_wa, sv_ra, mv_wa, mv_ra, gn_wa, gn_ra;
    skm_pkg::q_t   cov_wd, sv_wd, mv_wd, gn_wd;
    skm_pkg::q_t   cov_rd, sv_rd, mv_rd, gn_rd;

    logic          mul_start, mul_done;
    skm_pkg::q_t   mul_a, mul_b, mul_prod;
    logic          div_start, div_done, div_neg;
    logic [127:0]  div_num;
    logic [63:0]   div_den;
    skm_pkg::q_t   div_quo;

    logic [IW-1:0] n_m1;
    logic [TW-1:0] tj;
    logic [IW-1:0] cur_tidx;
    skm_pkg::q_t   cur_coef;
    logic          j_done;
    logic          stale;
    logic          repeat_hit;
    logic          a_bad, b_bad;
    logic          p_row_end, p_all_end;
    logic          cfg_wr;
    skm_pkg::q_t   beta_new;
    logic [63:0]   mv_mag;

    skm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    skm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .neg   (div_neg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(skm_pkg::APB_DW - skm_pkg::CFG_W){1'b0}}, sc_reg}
                                       : '0;

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_val_reg;
    assign out_ch.status       = out_st_reg;

    always_comb
    begin
        if (sc_reg == '0)
        begin
            n_m1 = '0;
        end
        else if (sc_reg > skm_pkg::CFG_W'(NS))
        begin
            n_m1 = IW'(NS - 1);
        end
        else
        begin
            n_m1 = IW'(sc_reg - 1'b1);
        end
        tj        = j_reg[TW-1:0];
        cur_tidx  = tidx_reg[tj];
        cur_coef  = tcoef_reg[tj];
        j_done    = (j_reg == IW'(tcnt_reg));
        a_bad     = a_reg > n_m1;
        b_bad     = b_reg > n_m1;
        p_row_end = (j_reg == n_m1);
        p_all_end = p_row_end && (i_reg == n_m1);
        stale      = 1'b0;
        repeat_hit = 1'b0;
        for (int k = 0; k < NT; k++)
        begin
            if (CW'(k) < tcnt_reg)
            begin
                if (tidx_reg[k] > n_m1)
                begin
                    stale = 1'b1;
                end
                if (tidx_reg[k] == a_reg)
                begin
                    repeat_hit = 1'b1;
                end
            end
        end
        beta_new = skm_pkg::sat_add(div_quo, acc_reg);
        mv_mag   = skm_pkg::mag_of(mv_rd);
    end

    always_comb
    begin
        case (phase_reg)
            PH_M:
            begin
                mul_a = cov_rd;
                mul_b = cur_coef;
            end
            PH_GM:
            begin
                mul_a = cur_coef;
                mul_b = mv_rd;
            end
            PH_GX:
            begin
                mul_a = cur_coef;
                mul_b = sv_rd;
            end
            PH_X:
            begin
                mul_a = gn_rd;
                mul_b = innov_reg;
            end
            default:
            begin
                mul_a = gn_rd;
                mul_b = mv_rd;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        act_next       = act_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        val_next       = val_reg;
        w_next         = w_reg;
        tidx_next      = tidx_reg;
        tcoef_next     = tcoef_reg;
        tcnt_next      = tcnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        beta_next      = beta_reg;
        innov_next     = innov_reg;
        pv_next        = pv_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;

        cov_we = 1'b0; cov_wa = '0; cov_wd = '0; cov_re = 1'b0; cov_ra = '0;
        sv_we  = 1'b0; sv_wa  = '0; sv_wd  = '0; sv_re  = 1'b0; sv_ra  = '0;
        mv_we  = 1'b0; mv_wa  = '0; mv_wd  = '0; mv_re  = 1'b0; mv_ra  = '0;
        gn_we  = 1'b0; gn_wa  = '0; gn_wd  = '0; gn_re  = 1'b0; gn_ra  = '0;
        mul_start = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_neg   = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    act_next   = in_ch.action;
                    a_next     = in_ch.index_a;
                    b_next     = in_ch.index_b;
                    val_next   = in_ch.value;
                    w_next     = in_ch.weight;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_val_next = '0;
                res_st_next  = skm_pkg::ST_OK;
                state_next   = S_RESP;
                unique case (act_reg)
                    skm_pkg::ACT_LOAD_X:
                    begin
                        if (a_bad)
                        begin
                            res_st_next = skm_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            sv_we = 1'b1;
                            sv_wa = a_reg;
                            sv_wd = val_reg;
                        end
                    end
                    skm_pkg::ACT_LOAD_P:
                    begin
                        if (a_bad || b_bad)
                        begin
                            res_st_next = skm_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            cov_we = 1'b1;
                            cov_wa = {a_reg, b_reg};
                            cov_wd = val_reg;
                        end
                    end
                    skm_pkg::ACT_ADD:
                    begin
                        if (a_bad)
                        begin
                            res_st_next = skm_pkg::ST_BADIDX;
                        end
                        else if (tcnt_reg == CW'(NT))
                        begin
                            res_st_next = skm_pkg::ST_FULL;
                        end
                        else if (repeat_hit)
                        begin
                            res_st_next = skm_pkg::ST_REPEAT;
                        end
                        else
                        begin
                            tidx_next[tcnt_reg[TW-1:0]]  = a_reg;
                            tcoef_next[tcnt_reg[TW-1:0]] = val_reg;
                            tcnt_next = tcnt_reg + 1'b1;
                        end
                    end
                    skm_pkg::ACT_UPDATE:
                    begin
                        state_next = S_CHECK;
                    end
                    skm_pkg::ACT_READ_X:
                    begin
                        if (a_bad)
                        begin
                            res_st_next = skm_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            sv_re      = 1'b1;
                            sv_ra      = a_reg;
                            state_next = S_READ;
                        end
                    end
                    skm_pkg::ACT_READ_P:
                    begin
                        if (a_bad || b_bad)
                        begin
                            res_st_next = skm_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            cov_re     = 1'b1;
                            cov_ra     = {a_reg, b_reg};
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_READ:
            begin
                res_val_next = (act_reg == skm_pkg::ACT_READ_X) ? sv_rd : cov_rd;
                state_next   = S_RESP;
            end
            S_CHECK:
            begin
                if (stale)
                begin
                    res_st_next = skm_pkg::ST_BADIDX;
                    state_next  = S_RESP;
                end
                else if (w_reg == '0)
                begin
                    res_st_next = skm_pkg::ST_NONPOS;
                    state_next  = S_RESP;
                end
                else
                begin
                    phase_next = PH_M;
                    i_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                case (phase_reg)
                    PH_M:
                    begin
                        if (j_done)
                        begin
                            mv_we    = 1'b1;
                            mv_wa    = i_reg;
                            mv_wd    = acc_reg;
                            acc_next = '0;
                            j_next   = '0;
                            if (i_reg == n_m1)
                            begin
                                phase_next = PH_GM;
                                i_next     = '0;
                            end
                            else
                            begin
                                i_next = i_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            cov_re     = 1'b1;
                            cov_ra     = {i_reg, cur_tidx};
                            state_next = S_MUL;
                        end
                    end
                    PH_GM:
                    begin
                        if (j_done)
                        begin
                            div_start  = 1'b1;
                            div_num    = {64'd1, 64'd0};
                            div_den    = {1'b0, w_reg};
                            phase_next = PH_BETA;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            mv_re      = 1'b1;
                            mv_ra      = cur_tidx;
                            state_next = S_MUL;
                        end
                    end
                    PH_GAIN:
                    begin
                        mv_re      = 1'b1;
                        mv_ra      = i_reg;
                        state_next = S_MUL;
                    end
                    PH_GX:
                    begin
                        if (j_done)
                        begin
                            innov_next = skm_pkg::sat_sub(val_reg, acc_reg);
                            phase_next = PH_X;
                            i_next     = '0;
                        end
                        else
                        begin
                            sv_re      = 1'b1;
                            sv_ra      = cur_tidx;
                            state_next = S_MUL;
                        end
                    end
                    PH_X:
                    begin
                        sv_re      = 1'b1;
                        sv_ra      = i_reg;
                        gn_re      = 1'b1;
                        gn_ra      = i_reg;
                        state_next = S_MUL;
                    end
                    PH_P:
                    begin
                        cov_re     = 1'b1;
                        cov_ra     = {i_reg, j_reg};
                        gn_re      = 1'b1;
                        gn_ra      = i_reg;
                        mv_re      = 1'b1;
                        mv_ra      = j_reg;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        state_next = S_DIV;
                    end
                endcase
            end
            S_MUL:
            begin
                if (phase_reg == PH_GAIN)
                begin
                    div_start  = 1'b1;
                    div_num    = {32'd0, mv_mag, 32'd0};
                    div_den    = beta_reg;
                    div_neg    = mv_rd[63];
                    state_next = S_DIV;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (mul_done)
                begin
                    case (phase_reg)
                        PH_X:
                        begin
                            sv_we = 1'b1;
                            sv_wa = i_reg;
                            sv_wd = skm_pkg::sat_add(sv_rd, mul_prod);
                            state_next = S_RD;
                            if (i_reg == n_m1)
                            begin
                                phase_next = PH_P;
                                i_next     = '0;
                                j_next     = '0;
                            end
                            else
                            begin
                                i_next = i_reg + 1'b1;
                            end
                        end
                        PH_P:
                        begin
                            cov_we  = 1'b1;
                            cov_wa  = {i_reg, j_reg};
                            cov_wd  = skm_pkg::sat_sub(cov_rd, mul_prod);
                            pv_next = cov_wd;
                            if (j_reg != i_reg)
                            begin
                                state_next = S_WR2;
                            end
                            else if (p_all_end)
                            begin
                                res_val_next = innov_reg;
                                state_next   = S_RESP;
                            end
                            else if (p_row_end)
                            begin
                                i_next     = i_reg + 1'b1;
                                j_next     = i_reg + 1'b1;
                                state_next = S_RD;
                            end
                            else
                            begin
                                j_next     = j_reg + 1'b1;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            acc_next   = skm_pkg::sat_add(acc_reg, mul_prod);
                            j_next     = j_reg + 1'b1;
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_WR2:
            begin
                cov_we = 1'b1;
                cov_wa = {j_reg, i_reg};
                cov_wd = pv_reg;
                if (p_all_end)
                begin
                    res_val_next = innov_reg;
                    state_next   = S_RESP;
                end
                else if (p_row_end)
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = i_reg + 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (phase_reg == PH_BETA)
                    begin
                        if (beta_new[63] || (beta_new == '0))
                        begin
                            res_st_next = skm_pkg::ST_NONPOS;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            beta_next  = beta_new;
                            phase_next = PH_GAIN;
                            i_next     = '0;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        gn_we      = 1'b1;
                        gn_wa      = i_reg;
                        gn_wd      = div_quo;
                        state_next = S_RD;
                        if (i_reg == n_m1)
                        begin
                            phase_next = PH_GX;
                            j_next     = '0;
                            acc_next   = '0;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_st_next    = res_st_reg;
                    if (act_reg == skm_pkg::ACT_UPDATE)
                    begin
                        tcnt_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_M;
            tcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            sc_reg        <= skm_pkg::CFG_W'(NS);
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            tcnt_reg      <= tcnt_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            if (cfg_wr)
            begin
                sc_reg <= pwdata[skm_pkg::CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        val_reg     <= val_next;
        w_reg       <= w_next;
        tidx_reg    <= tidx_next;
        tcoef_reg   <= tcoef_next;
        acc_reg     <= acc_next;
        beta_reg    <= beta_next;
        innov_reg   <= innov_next;
        pv_reg      <= pv_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (cov_we)
        begin
            cov_mem[cov_wa] <= cov_wd;
        end
        if (cov_re)
        begin
            cov_rd <= cov_mem[cov_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
        begin
            sv_mem[sv_wa] <= sv_wd;
        end
        if (sv_re)
        begin
            sv_rd <= sv_mem[sv_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv_we)
        begin
            mv_mem[mv_wa] <= mv_wd;
        end
        if (mv_re)
        begin
            mv_rd <= mv_mem[mv_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gn_we)
        begin
            gn_mem[gn_wa] <= gn_wd;
        end
        if (gn_re)
        begin
            gn_rd <= gn_mem[gn_ra];
        end
    end

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("accepted a word while a command was in flight");

    a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tcnt_reg <= CW'(NT))
        else $error("term count beyond buffer depth");

    a_unit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished together");
`endif

endmodule
`default_nettype wire
